@@ design/pic_pkg.sv @@
package pic_pkg;

    localparam int MAX_INTERVALS = 1024;

    localparam int POS_W   = 31;
    localparam int CNTR_W  = 32;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
    localparam int ENTRY_W = 2 * POS_W;

    localparam int IN_DATA_W  = ((3 * POS_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 3 * CNTR_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             go;
        logic [POS_W-1:0] point;
        logic [CNT_W-1:0] count;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

endpackage

@@ design/pic_ram.sv @@
module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/pic_scan.sv @@
module pic_scan
    import pic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_req_t          req,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [ENTRY_W-1:0] rd_data,
    output scan_rsp_t          rsp
);

    logic             issuing_reg, issuing_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             cmp_last_reg, cmp_last_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic [POS_W-1:0] point_reg, point_next;

    logic [POS_W-1:0] entry_start;
    logic [POS_W-1:0] entry_end;
    logic             entry_hit;
    logic             at_last;

    // entry layout: start in the low half, end in the high half
    assign entry_start = rd_data[POS_W-1:0];
    assign entry_end   = rd_data[ENTRY_W-1:POS_W];
    assign entry_hit   = cmp_valid_reg && (entry_start <= point_reg) && (entry_end >= point_reg);
    assign at_last     = (addr_reg == last_reg);

    assign rd_en   = issuing_reg;
    assign rd_addr = addr_reg[ADDR_W-1:0];

    assign rsp.done = cmp_valid_reg && cmp_last_reg;
    assign rsp.hit  = hit_reg || entry_hit;

    always_comb
    begin
        issuing_next   = issuing_reg;
        cmp_valid_next = issuing_reg;
        cmp_last_next  = issuing_reg && at_last;
        hit_next       = hit_reg || entry_hit;
        addr_next      = addr_reg;
        last_next      = last_reg;
        point_next     = point_reg;
        if (req.go)
        begin
            issuing_next = 1'b1;
            hit_next     = 1'b0;
            addr_next    = '0;
            last_next    = req.count - CNT_W'(1);
            point_next   = req.point;
        end
        else if (issuing_reg)
        begin
            addr_next = addr_reg + CNT_W'(1);
            if (at_last)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            addr_reg      <= '0;
            last_reg      <= '0;
        end
        else
        begin
            issuing_reg   <= issuing_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            hit_reg       <= hit_next;
            addr_reg      <= addr_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

`ifndef ASSERT_OFF
    a_no_go_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> !issuing_reg && !cmp_valid_reg)
        else $error("scan started while busy");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issuing_reg |-> addr_reg <= last_reg)
        else $error("scan address past last entry");

    a_done_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !issuing_reg)
        else $error("scan done while reads still issuing");
`endif

endmodule

@@ design/point_in_interval_counter.sv @@
// channel  dir  tdata (low bit up)                            tuser
// s_*      in   interval_start, interval_end, point_position  command
// m_*      out  total_points, inside_points, outside_points,  -
//               table_overflow
//
// Clear, add and report are handled in the idle state without a scan. A query
// reads each stored entry in turn through the single read port and compares
// each entry as its read data returns; a query on an empty table only counts the point.
// rst_n clears counters, entry count and overflow; the table is not cleared.
// A report waits while the output register holds an untaken transfer.
module point_in_interval_counter
    import pic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // interval_start, interval_end, point_position
    input  logic [CMD_W-1:0]      s_tuser,  // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // total, inside, outside, table_overflow
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNTR_W-1:0]     total_reg, total_next;
    logic [CNTR_W-1:0]     inside_reg, inside_next;
    logic                  overflow_reg, overflow_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    cmd_t              cmd;
    logic [POS_W-1:0]  in_start;
    logic [POS_W-1:0]  in_end;
    logic [POS_W-1:0]  in_point;
    logic              accept;
    logic              table_full;
    logic [CNTR_W-1:0] total_inc;

    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    scan_req_t          scan_req;
    scan_rsp_t          scan_rsp;

    assign cmd      = cmd_t'(s_tuser);
    assign in_start = s_tdata[POS_W-1:0];
    assign in_end   = s_tdata[2*POS_W-1:POS_W];
    assign in_point = s_tdata[3*POS_W-1:2*POS_W];

    assign s_tready   = (state_reg == ST_IDLE)
                        && ((cmd != CMD_REPORT) || !out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign table_full = (count_reg == CNT_W'(MAX_INTERVALS));
    assign total_inc  = (total_reg == '1) ? total_reg : total_reg + CNTR_W'(1);

    assign wr_en = accept && (cmd == CMD_ADD) && !table_full;

    assign scan_req.go    = accept && (cmd == CMD_QUERY) && (count_reg != '0);
    assign scan_req.point = in_point;
    assign scan_req.count = count_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // table writes happen only in idle and reads only while scanning,
    // so the same entry is never read and written together
    pic_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({in_end, in_start}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pic_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (scan_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        inside_next    = inside_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next    = '0;
                            total_next    = '0;
                            inside_next   = '0;
                            overflow_next = 1'b0;
                        end
                        CMD_ADD:
                        begin
                            if (table_full)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                total_next = total_inc;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_REPORT:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = OUT_DATA_W'({overflow_reg,
                                                          total_reg - inside_reg,
                                                          inside_reg,
                                                          total_reg});
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    total_next = total_inc;
                    if (scan_rsp.hit && (inside_reg < total_inc))
                    begin
                        inside_next = inside_reg + CNTR_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            inside_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            inside_reg    <= inside_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_inside_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg <= total_reg)
        else $error("inside count above total");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("entry count above table depth");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_rsp.done |-> state_reg == ST_SCAN)
        else $error("scan result outside of scan state");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> count_reg != '0)
        else $error("scan of an empty table");
`endif

endmodule

@@ bench/interval_count_checker.sv @@
`timescale 1ns / 100ps

module interval_count_checker
    import pic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    error_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [CNTR_W-1:0] total_points;
        logic [CNTR_W-1:0] inside_points;
        logic [CNTR_W-1:0] outside_points;
        logic              table_overflow;
    } count_report_t;

    logic [POS_W-1:0]  lo_mem [MAX_INTERVALS];
    logic [POS_W-1:0]  hi_mem [MAX_INTERVALS];
    int unsigned       stored;
    logic [CNTR_W-1:0] total_cnt;
    logic [CNTR_W-1:0] hit_cnt;
    logic              ovf;
    count_report_t     report_q[$];
    int                mismatch_count;

    function automatic bit covered(input logic [POS_W-1:0] pos);
        for (int unsigned i = 0; i < stored; i++)
        begin
            if (lo_mem[i] <= pos && hi_mem[i] >= pos)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        count_report_t got;
        count_report_t want;
        if (!rst_n)
        begin
            stored = 0;
            total_cnt = '0;
            hit_cnt = '0;
            ovf = 1'b0;
            report_q.delete();
            mismatch_count = 0;
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result register holds an older report, so retire before predicting
            if (m_tvalid && m_tready)
            begin
                got.total_points   = m_tdata[CNTR_W-1:0];
                got.inside_points  = m_tdata[2*CNTR_W-1:CNTR_W];
                got.outside_points = m_tdata[3*CNTR_W-1:2*CNTR_W];
                got.table_overflow = m_tdata[3*CNTR_W];
                if (report_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: unexpected count report total %0d inside %0d",
                                  " outside %0d overflow %0d"},
                                 $time, got.total_points, got.inside_points,
                                 got.outside_points, got.table_overflow);
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.total_points !== want.total_points
                        || got.inside_points !== want.inside_points
                        || got.outside_points !== want.outside_points
                        || got.table_overflow !== want.table_overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: count report mismatch", $time);
                            $display("    expected total %0d inside %0d outside %0d overflow %0d",
                                     want.total_points, want.inside_points,
                                     want.outside_points, want.table_overflow);
                            $display("    actual   total %0d inside %0d outside %0d overflow %0d",
                                     got.total_points, got.inside_points,
                                     got.outside_points, got.table_overflow);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                case (cmd_t'(s_tuser))
                    CMD_CLEAR:
                    begin
                        stored = 0;
                        total_cnt = '0;
                        hit_cnt = '0;
                        ovf = 1'b0;
                    end
                    CMD_ADD:
                    begin
                        if (stored >= MAX_INTERVALS)
                            ovf = 1'b1;
                        else
                        begin
                            lo_mem[stored] = s_tdata[POS_W-1:0];
                            hi_mem[stored] = s_tdata[2*POS_W-1:POS_W];
                            stored++;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (total_cnt != '1)
                            total_cnt = total_cnt + 1'b1;
                        if (covered(s_tdata[3*POS_W-1:2*POS_W]) && hit_cnt < total_cnt)
                            hit_cnt = hit_cnt + 1'b1;
                    end
                    default:
                    begin
                        want.total_points   = total_cnt;
                        want.inside_points  = hit_cnt;
                        want.outside_points = total_cnt - hit_cnt;
                        want.table_overflow = ovf;
                        report_q.insert(report_q.size(), want);
                    end
                endcase
            end

            error_count <= mismatch_count;
            outstanding <= report_q.size();
        end
    end

endmodule

@@ bench/point_in_interval_counter_tb.sv @@
`timescale 1ns / 100ps

module point_in_interval_counter_tb;
    import pic_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int FILL_ITEMS   = 128;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = MAX_INTERVALS + 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = CMD_CLEAR;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int error_count;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_go = 1'b0;
    int cycle_count = 0;
    int sent = 0;

    // intervals currently in the block, used to aim query points
    logic [POS_W-1:0] iv_lo[$];
    logic [POS_W-1:0] iv_hi[$];

    point_in_interval_counter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    interval_count_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom());
    endfunction

    // one transfer on the input channel; called and returns at a rising edge
    task automatic offer_command(input cmd_t cmd, input logic [POS_W-1:0] lo,
                                 input logic [POS_W-1:0] hi, input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_W-3*POS_W){1'b0}}, pos, hi, lo};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        if (cmd == CMD_CLEAR)
        begin
            iv_lo.delete();
            iv_hi.delete();
        end
        else if (cmd == CMD_ADD && iv_lo.size() < MAX_INTERVALS)
        begin
            iv_lo.insert(iv_lo.size(), lo);
            iv_hi.insert(iv_hi.size(), hi);
        end
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic next_interval(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
        logic [31:0]      span;
        logic [31:0]      far;
        logic [POS_W-1:0] tmp;
        lo = rand_pos();
        case ($urandom_range(7))
            0: lo = '0;
            1: lo = POS_MAX - POS_W'($urandom_range(3));
            default: ;
        endcase
        case ($urandom_range(3))
            0: span = $urandom_range(16);
            1: span = $urandom_range(100000);
            2: span = $urandom_range(50000000);
            default: span = $urandom() >> 1;
        endcase
        far = {1'b0, lo} + span;
        hi = (far > {1'b0, POS_MAX}) ? POS_MAX : far[POS_W-1:0];
        if ($urandom_range(9) == 0 && lo != hi)
        begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
    endtask

    function automatic logic [POS_W-1:0] pick_point();
        int k;
        if (iv_lo.size() == 0 || $urandom_range(9) < 3)
            return rand_pos();
        k = $urandom_range(iv_lo.size() - 1);
        case ($urandom_range(4))
            0: return iv_lo[k];
            1: return iv_hi[k];
            2: return iv_lo[k] - 1'b1;
            3: return iv_hi[k] + 1'b1;
            default:
            begin
                if (iv_lo[k] <= iv_hi[k])
                    return iv_lo[k] + POS_W'($urandom_range(iv_hi[k] - iv_lo[k]));
                return iv_lo[k];
            end
        endcase
    endfunction

    // usually a clear, then a few intervals, a burst of points, report; sometimes a stray command instead
    task automatic run_sequence();
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        int               n_add;
        int               n_query;
        if ($urandom_range(9) == 0)
        begin
            offer_command(cmd_t'($urandom_range(3)), rand_pos(), rand_pos(), pick_point());
            return;
        end
        if ($urandom_range(9) < 8 || iv_lo.size() > 48)
            offer_command(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos());
        n_add = $urandom_range(12);
        n_query = $urandom_range(1, 10);
        repeat (n_add)
        begin
            next_interval(lo, hi);
            offer_command(CMD_ADD, lo, hi, rand_pos());
        end
        repeat (n_query)
            offer_command(CMD_QUERY, rand_pos(), rand_pos(), pick_point());
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
    endtask

    initial
    begin
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        int               base;
        int               phase;
        int               cur_phase;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, edge positions, reversed interval, boundaries, clear
        offer_command(CMD_REPORT, POS_MAX, POS_MAX, POS_MAX);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd5);
        offer_command(CMD_ADD, '0, '0, POS_MAX);
        offer_command(CMD_ADD, POS_MAX, POS_MAX, '0);
        offer_command(CMD_ADD, 31'd100, 31'd50, rand_pos());
        offer_command(CMD_QUERY, POS_MAX, POS_MAX, '0);
        offer_command(CMD_QUERY, '0, '0, POS_MAX);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd75);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd1);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd100);
        offer_command(CMD_REPORT, '0, '0, '0);
        offer_command(CMD_ADD, 31'd10, 31'd20, rand_pos());
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd10);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd20);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd9);
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), 31'd21);
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_CLEAR, POS_MAX, POS_MAX, POS_MAX);
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_ADD, '0, POS_MAX, rand_pos());
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_QUERY, rand_pos(), rand_pos(), '0);
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_CLEAR, '0, '0, '0);
        drain_reports();

        base = sent;
        cur_phase = 0;
        tx_idle_pct = 32;
        rx_idle_pct = 86;
        while (sent - base < RANDOM_ITEMS)
        begin
            phase = (sent - base) * 3 / RANDOM_ITEMS;
            if (phase != cur_phase)
            begin
                drain_reports();
                cur_phase = phase;
                if (phase == 1)
                begin
                    // long output stall with reports queued behind it
                    tx_idle_pct = 0;
                    hold_go = 1'b1;
                    offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
                    offer_command(CMD_QUERY, rand_pos(), rand_pos(), pick_point());
                    offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
                    offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
                    offer_command(CMD_QUERY, rand_pos(), rand_pos(), pick_point());
                    offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
                    drain_reports();
                    tx_idle_pct = 86;
                    rx_idle_pct = 32;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            end
            run_sequence();
        end
        drain_reports();

        // load a larger table, scan it several times, then clear
        offer_command(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos());
        repeat (FILL_ITEMS)
        begin
            next_interval(lo, hi);
            offer_command(CMD_ADD, lo, hi, rand_pos());
        end
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
        repeat (6)
            offer_command(CMD_QUERY, rand_pos(), rand_pos(), pick_point());
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos());
        offer_command(CMD_REPORT, rand_pos(), rand_pos(), rand_pos());

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
